// ===== hdl/wiem_pkg.sv =====
// Package for the water ingress event monitor.
// Holds the channel payload structs, configuration and state structs, event codes
// and reset constants. Depends on nothing.
package wiem_pkg;

  localparam int SAMPLE_BITS  = 10;
  localparam int TICK_BITS    = 24;
  localparam int SECONDS_BITS = 16;
  localparam int SHIFT_BITS   = 4;
  localparam int CFG_IDX_BITS = 2;
  localparam int RES_DEPTH    = 4;
  localparam int RES_PTR_W    = $clog2(RES_DEPTH);
  localparam int RES_CNT_W    = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    EV_DETECTED  = 2'd0,
    EV_PRESENT   = 2'd1,
    EV_CLEARED   = 2'd2,
    EV_HEARTBEAT = 2'd3
  } ev_code_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WET_LIMIT          = 2'd0,
    CFG_REPORT_INTERVAL    = 2'd1,
    CFG_HEARTBEAT_INTERVAL = 2'd2,
    CFG_TICK_RATE_SHIFT    = 2'd3
  } cfg_idx_t;

  localparam logic [SAMPLE_BITS-1:0] WET_LIMIT_RST          = SAMPLE_BITS'(512);
  localparam logic [TICK_BITS-1:0]   REPORT_INTERVAL_RST    = TICK_BITS'(480);
  localparam logic [TICK_BITS-1:0]   HEARTBEAT_INTERVAL_RST = TICK_BITS'(691200);
  localparam logic [SHIFT_BITS-1:0]  TICK_RATE_SHIFT_RST    = SHIFT_BITS'(3);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_forward;
    logic [SAMPLE_BITS-1:0] sample_reverse;
    logic [TICK_BITS-1:0]   now_tick;
  } in_t;

  typedef struct packed {
    ev_code_t                event_code;
    logic [SECONDS_BITS-1:0] elapsed_seconds;
    logic [SAMPLE_BITS-1:0]  conductivity;
    logic                    last_of_run;
  } out_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] wet_limit;
    logic [TICK_BITS-1:0]   report_interval;
    logic [TICK_BITS-1:0]   heartbeat_interval;
    logic [SHIFT_BITS-1:0]  tick_rate_shift;
  } cfg_t;

  typedef struct packed {
    logic                 wet_flag;
    logic [TICK_BITS-1:0] wet_start;
    logic [TICK_BITS-1:0] last_report;
    logic [TICK_BITS-1:0] last_heartbeat;
  } state_t;

  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
    logic       wet_nxt;
    logic       set_start;
    logic       set_report;
    logic       set_heartbeat;
  } eval_t;

endpackage

// ===== hdl/wiem_eval.sv =====
// Decision logic for one sense cycle: average, wet test, interval checks, seconds.
// Produces up to two results and the state update. Depends on wiem_pkg.
module wiem_eval (
  input  wiem_pkg::in_t    item,
  input  wiem_pkg::cfg_t   cfg,
  input  wiem_pkg::state_t st,
  output wiem_pkg::eval_t  ev
);

  logic [wiem_pkg::SAMPLE_BITS:0]    sum;
  logic [wiem_pkg::SAMPLE_BITS-1:0]  cond;
  logic                              wet;
  logic [wiem_pkg::TICK_BITS-1:0]    since_start;
  logic [wiem_pkg::TICK_BITS-1:0]    since_report;
  logic [wiem_pkg::TICK_BITS-1:0]    since_hb;
  logic [wiem_pkg::TICK_BITS-1:0]    shifted;
  logic [wiem_pkg::SECONDS_BITS-1:0] secs;
  logic                              report_due;
  logic                              hb_due;
  wiem_pkg::out_t                    res_a;
  wiem_pkg::out_t                    res_b;

  assign sum  = {1'b0, item.sample_forward} + {1'b0, item.sample_reverse};
  assign cond = sum[wiem_pkg::SAMPLE_BITS:1];
  assign wet  = cond > cfg.wet_limit;

  assign since_start  = item.now_tick - st.wet_start;
  assign since_report = item.now_tick - st.last_report;
  assign since_hb     = item.now_tick - st.last_heartbeat;
  assign report_due   = since_report >= cfg.report_interval;
  assign hb_due       = since_hb >= cfg.heartbeat_interval;

  assign shifted = since_start >> cfg.tick_rate_shift;
  assign secs    = (|shifted[wiem_pkg::TICK_BITS-1:wiem_pkg::SECONDS_BITS])
                   ? {wiem_pkg::SECONDS_BITS{1'b1}}
                   : shifted[wiem_pkg::SECONDS_BITS-1:0];

  always_comb begin
    res_a                 = '0;
    res_a.conductivity    = cond;
    res_b                 = res_a;
    ev                    = '0;
    ev.wet_nxt            = st.wet_flag;
    if (wet) begin
      if (!st.wet_flag) begin
        ev.wet_nxt         = 1'b1;
        ev.set_start       = 1'b1;
        ev.set_report      = 1'b1;
        ev.n               = 2'd1;
        res_a.event_code   = wiem_pkg::EV_DETECTED;
        res_a.last_of_run  = 1'b1;
      end else if (report_due) begin
        ev.set_report          = 1'b1;
        ev.n                   = 2'd1;
        res_a.event_code       = wiem_pkg::EV_PRESENT;
        res_a.elapsed_seconds  = secs;
        res_a.last_of_run      = 1'b1;
      end
    end else begin
      ev.wet_nxt = 1'b0;
      if (st.wet_flag) begin
        res_a.event_code      = wiem_pkg::EV_CLEARED;
        res_a.elapsed_seconds = secs;
        if (hb_due) begin
          ev.n              = 2'd2;
          ev.set_heartbeat  = 1'b1;
          res_b.event_code  = wiem_pkg::EV_HEARTBEAT;
          res_b.last_of_run = 1'b1;
        end else begin
          ev.n              = 2'd1;
          res_a.last_of_run = 1'b1;
        end
      end else if (hb_due) begin
        ev.n              = 2'd1;
        ev.set_heartbeat  = 1'b1;
        res_a.event_code  = wiem_pkg::EV_HEARTBEAT;
        res_a.last_of_run = 1'b1;
      end
    end
    ev.r0 = res_a;
    ev.r1 = res_b;
  end

endmodule

// ===== hdl/wiem_rfifo.sv =====
// Result queue: takes zero, one or two results per cycle, delivers one.
// Depends on wiem_pkg.
module wiem_rfifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [1:0]                      push_n,
  input  wiem_pkg::out_t                  push0,
  input  wiem_pkg::out_t                  push1,
  input  logic                            pop,
  output wiem_pkg::out_t                  head,
  output logic [wiem_pkg::RES_CNT_W-1:0]  count
);

  wiem_pkg::out_t                   mem [wiem_pkg::RES_DEPTH];
  logic [wiem_pkg::RES_PTR_W-1:0]   wr_ptr_r;
  logic [wiem_pkg::RES_PTR_W-1:0]   wr_ptr_nxt;
  logic [wiem_pkg::RES_PTR_W-1:0]   rd_ptr_r;
  logic [wiem_pkg::RES_PTR_W-1:0]   rd_ptr_nxt;
  logic [wiem_pkg::RES_CNT_W-1:0]   count_r;
  logic [wiem_pkg::RES_CNT_W-1:0]   count_nxt;

  assign wr_ptr_nxt = wr_ptr_r + wiem_pkg::RES_PTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + wiem_pkg::RES_PTR_W'(pop);
  assign count_nxt  = count_r + wiem_pkg::RES_CNT_W'(push_n) - wiem_pkg::RES_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_r + wiem_pkg::RES_PTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head  = mem[rd_ptr_r];
  assign count = count_r;

endmodule

// ===== hdl/water_ingress_event_monitor.sv =====
// Top level of the water ingress event monitor.
// Depends on wiem_pkg, wiem_eval and wiem_rfifo.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one sense cycle: two
//   electrode samples and the current tick count. Result channel (out_valid,
//   out_stall, out_data) carries detected, present, cleared and heartbeat events,
//   zero to two per sense cycle, with last_of_run on the final one.
//   Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the wet
//   limit, report interval, heartbeat interval and tick rate shift; cfg_ready
//   is always high. Write only while no transaction is in flight.
//   Path: the input register holds a transaction until the result queue has room
//   for two; its results are then written to the queue, which raises out_valid.
//   Throughput: one transaction per cycle while the four-entry result queue has
//   room for two; the output drains one result per cycle while out_stall is low,
//   so sustained throughput is set by the result port.
//   A stalled receiver fills the queue until it lacks room for two, then in_stall
//   rises and holds the input register. Synchronous reset restores register
//   defaults, clears the wet state and timers and empties the queue.
module water_ingress_event_monitor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wiem_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wiem_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wiem_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [wiem_pkg::TICK_BITS-1:0]      cfg_data
);

  wiem_pkg::cfg_t                   cfg_r;
  wiem_pkg::cfg_t                   cfg_nxt;
  wiem_pkg::state_t                 st_r;
  wiem_pkg::state_t                 st_nxt;
  wiem_pkg::in_t                    s1_data_r;
  logic                             s1_valid_r;
  logic                             s1_valid_nxt;
  wiem_pkg::eval_t                  ev;
  logic                             room;
  logic                             advance;
  logic                             in_take;
  logic                             pop;
  logic [1:0]                       push_n;
  logic [wiem_pkg::RES_CNT_W-1:0]   res_count;

  assign cfg_ready = 1'b1;
  assign room      = res_count <= wiem_pkg::RES_CNT_W'(wiem_pkg::RES_DEPTH - 2);
  assign advance   = s1_valid_r && room;
  assign in_stall  = s1_valid_r && !room;
  assign in_take   = in_valid && !in_stall;
  assign push_n    = advance ? ev.n : 2'd0;
  assign out_valid = res_count != '0;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (wiem_pkg::cfg_idx_t'(cfg_index))
        wiem_pkg::CFG_WET_LIMIT:
          cfg_nxt.wet_limit = cfg_data[wiem_pkg::SAMPLE_BITS-1:0];
        wiem_pkg::CFG_REPORT_INTERVAL:
          cfg_nxt.report_interval = cfg_data;
        wiem_pkg::CFG_HEARTBEAT_INTERVAL:
          cfg_nxt.heartbeat_interval = cfg_data;
        wiem_pkg::CFG_TICK_RATE_SHIFT:
          cfg_nxt.tick_rate_shift = cfg_data[wiem_pkg::SHIFT_BITS-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (advance) begin
      st_nxt.wet_flag = ev.wet_nxt;
      if (ev.set_start) begin
        st_nxt.wet_start = s1_data_r.now_tick;
      end
      if (ev.set_report) begin
        st_nxt.last_report = s1_data_r.now_tick;
      end
      if (ev.set_heartbeat) begin
        st_nxt.last_heartbeat = s1_data_r.now_tick;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wet_limit          <= wiem_pkg::WET_LIMIT_RST;
      cfg_r.report_interval    <= wiem_pkg::REPORT_INTERVAL_RST;
      cfg_r.heartbeat_interval <= wiem_pkg::HEARTBEAT_INTERVAL_RST;
      cfg_r.tick_rate_shift    <= wiem_pkg::TICK_RATE_SHIFT_RST;
      st_r                     <= '0;
      s1_valid_r               <= 1'b0;
    end else begin
      cfg_r      <= cfg_nxt;
      st_r       <= st_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  wiem_eval u_eval (
    .item (s1_data_r),
    .cfg  (cfg_r),
    .st   (st_r),
    .ev   (ev)
  );

  wiem_rfifo u_rfifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_n),
    .push0  (ev.r0),
    .push1  (ev.r1),
    .pop    (pop),
    .head   (out_data),
    .count  (res_count)
  );

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_count <= wiem_pkg::RES_CNT_W'(wiem_pkg::RES_DEPTH))
    else $error("result queue overflow");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && ev.n == 2'd2) |->
      (ev.r0.event_code == wiem_pkg::EV_CLEARED &&
       ev.r1.event_code == wiem_pkg::EV_HEARTBEAT && ev.r1.last_of_run))
    else $error("two results must be cleared then heartbeat");

  a_detect_on_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !st_r.wet_flag && ev.wet_nxt) |->
      (ev.n == 2'd1 && ev.r0.event_code == wiem_pkg::EV_DETECTED))
    else $error("dry-to-wet change without detected result");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && ev.n != 2'd0) |=> out_valid)
    else $error("pushed result not presented");
`endif

endmodule
